>>> design/huffman_tree_walk_decoder_assert.svh
// Assertion macros shared by the tree-walk decoder modules
`ifndef HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH

// Condition implies consequence in the same cycle
`define HTW_ASSERT_IMPLIES(name, ck, rn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle
`define HTW_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

// Condition never holds
`define HTW_ASSERT_NEVER(name, ck, rn, bad, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) !(bad)) \
    else $error(msg);

`endif

>>> design/htw_pkg.sv
// Shared types, codes and helpers for the tree-walk decoder
`timescale 1ns / 1ps
`default_nettype none

package htw_pkg;

  localparam int NODE_DEPTH_DEF   = 512;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int CMD_QDEPTH       = 4;
  localparam int TOK_QDEPTH       = 4;

  // Input operation codes
  localparam logic [1:0] OP_NODE_WR = 2'd0;
  localparam logic [1:0] OP_CNT_WR  = 2'd1;
  localparam logic [1:0] OP_DECODE  = 2'd2;

  typedef enum logic [1:0] {
    CMD_NODE = 2'd0,
    CMD_CNT  = 2'd1,
    CMD_DEC  = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    TOK_SYM  = 2'd0,
    TOK_EOB  = 2'd1,
    TOK_LOAD = 2'd2
  } tok_kind_t;

  // Classified command, node indices already wrapped into the table
  typedef struct packed {
    cmd_kind_t   kind;
    logic [8:0]  node_index;
    logic        node_is_leaf;
    logic [7:0]  symbol;
    logic [8:0]  left_child;
    logic [8:0]  right_child;
    logic [31:0] symbol_count;
    logic [7:0]  data_byte;
  } cmd_t;

  // One node table entry
  typedef struct packed {
    logic       leaf;
    logic [7:0] sym;
    logic [8:0] left;
    logic [8:0] right;
  } node_t;

  // Event from the tree walker to the count stage
  typedef struct packed {
    tok_kind_t   kind;
    logic        eob;
    logic        is_cnt;
    logic [7:0]  sym;
    logic [31:0] count;
  } tok_t;

  // Reduce a node index modulo the table depth by binary compare-subtract
  function automatic logic [8:0] wrap_idx(input logic [8:0] idx, input int unsigned depth);
    int unsigned rem;
    rem = 32'(idx);
    for (int k = 7; k >= 0; k--) begin
      if (rem >= (depth << k)) begin
        rem = rem - (depth << k);
      end
    end
    return rem[8:0];
  endfunction

endpackage

`default_nettype wire

>>> design/htw_if.sv
// Input and result channel interfaces of the tree-walk decoder
`timescale 1ns / 1ps
`default_nettype none

interface htw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [8:0]  node_index;
  logic        node_is_leaf;
  logic [7:0]  symbol;
  logic [8:0]  left_child;
  logic [8:0]  right_child;
  logic [31:0] symbol_count;
  logic [7:0]  data_byte;

  modport source (
    output valid, operation, node_index, node_is_leaf, symbol, left_child,
           right_child, symbol_count, data_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, node_index, node_is_leaf, symbol, left_child,
           right_child, symbol_count, data_byte,
    output ready
  );
endinterface

interface htw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] decoded_symbol;
  logic       last_in_run;
  logic       stopped;

  modport source (output valid, decoded_symbol, last_in_run, stopped, input ready);
  modport sink (input valid, decoded_symbol, last_in_run, stopped, output ready);
endinterface

`default_nettype wire

>>> design/htw_fifo.sv
// Small register queue between decoder sections
`timescale 1ns / 1ps
`default_nettype none

module htw_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = htw_pkg::CMD_QDEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             push, pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> design/htw_front.sv
// Front end: accept input items, classify operations, wrap node indices
`timescale 1ns / 1ps
`default_nettype none

module htw_front #(
  parameter int NODE_DEPTH = htw_pkg::NODE_DEPTH_DEF
) (
  htw_in_if.sink            in_ch,
  output logic              cmd_valid,
  input  wire logic         cmd_ready,
  output htw_pkg::cmd_t     cmd
);

  logic keep;

  // Classify the operation; unused codes are taken and dropped
  always_comb begin
    keep     = 1'b1;
    cmd.kind = htw_pkg::CMD_DEC;
    unique case (in_ch.operation)
      htw_pkg::OP_NODE_WR: cmd.kind = htw_pkg::CMD_NODE;
      htw_pkg::OP_CNT_WR:  cmd.kind = htw_pkg::CMD_CNT;
      htw_pkg::OP_DECODE:  cmd.kind = htw_pkg::CMD_DEC;
      default:             keep     = 1'b0;
    endcase
  end

  // Fold node indices into the table range
  assign cmd.node_index   = htw_pkg::wrap_idx(in_ch.node_index, NODE_DEPTH);
  assign cmd.left_child   = htw_pkg::wrap_idx(in_ch.left_child, NODE_DEPTH);
  assign cmd.right_child  = htw_pkg::wrap_idx(in_ch.right_child, NODE_DEPTH);
  assign cmd.node_is_leaf = in_ch.node_is_leaf;
  assign cmd.symbol       = in_ch.symbol;
  assign cmd.symbol_count = in_ch.symbol_count;
  assign cmd.data_byte    = in_ch.data_byte;

  assign cmd_valid   = in_ch.valid && keep;
  assign in_ch.ready = cmd_ready || !keep;

endmodule

`default_nettype wire

>>> design/htw_walk.sv
// Tree walker: one node-table read per coded bit, node writes, event tokens
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_tree_walk_decoder_assert.svh"

module htw_walk #(
  parameter int NODE_DEPTH = htw_pkg::NODE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire htw_pkg::cmd_t  cmd,
  output logic                tok_valid,
  input  wire logic           tok_ready,
  output htw_pkg::tok_t       tok
);

  localparam int NodeAw = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;

  htw_pkg::node_t node_mem [0:NODE_DEPTH-1];

  htw_pkg::node_t mem_q_r, byp_r, cur_r, root_r;
  logic           busy_r, arr_v_r, arr_byp_r, arr_eob_r, at_root_r;
  logic [7:0]     byte_r;
  logic [2:0]     bit_r;

  htw_pkg::node_t arr_node, cur_c, node_wr;
  logic           adv, issue, cur_bit, rd_en, wr_en;
  logic           load_rdy, load_go, dec_go, arr_tok;
  logic [8:0]     next_idx;
  logic [NodeAw-1:0] rd_addr, wr_addr;

  // Resolve the node at the walk position
  assign adv      = tok_ready;
  assign arr_node = arr_byp_r ? byp_r : mem_q_r;
  always_comb begin
    if (arr_v_r) begin
      cur_c = arr_node.leaf ? root_r : arr_node;
    end else begin
      cur_c = at_root_r ? root_r : cur_r;
    end
  end

  // Step one bit; a leaf at the position is passed on without a read
  assign issue    = busy_r;
  assign cur_bit  = byte_r[bit_r];
  assign next_idx = cur_bit ? cur_c.right : cur_c.left;
  assign rd_addr  = NodeAw'(next_idx);
  assign rd_en    = adv && issue && !cur_c.leaf;

  // Take commands: decodes refill at the last bit, loads wait for a quiet walker
  assign load_rdy  = cmd_valid && (cmd.kind != htw_pkg::CMD_DEC) && !busy_r && !arr_v_r;
  assign load_go   = adv && load_rdy;
  assign dec_go    = adv && cmd_valid && (cmd.kind == htw_pkg::CMD_DEC)
                     && (!busy_r || bit_r == 3'd0);
  assign cmd_ready = load_go || dec_go;
  assign wr_en     = load_go && (cmd.kind == htw_pkg::CMD_NODE);
  assign wr_addr   = NodeAw'(cmd.node_index);
  assign node_wr   = '{leaf: cmd.node_is_leaf, sym: cmd.symbol,
                       left: cmd.left_child, right: cmd.right_child};

  // Build the event token for this cycle
  assign arr_tok   = arr_v_r && (arr_node.leaf || arr_eob_r);
  assign tok_valid = arr_tok || load_rdy;
  always_comb begin
    tok.kind   = htw_pkg::TOK_LOAD;
    tok.eob    = arr_eob_r;
    tok.is_cnt = (cmd.kind == htw_pkg::CMD_CNT);
    tok.sym    = cmd.symbol;
    tok.count  = cmd.symbol_count;
    if (arr_v_r) begin
      tok.kind = arr_node.leaf ? htw_pkg::TOK_SYM : htw_pkg::TOK_EOB;
      tok.sym  = arr_node.sym;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      arr_v_r   <= 1'b0;
      arr_byp_r <= 1'b0;
      arr_eob_r <= 1'b0;
      at_root_r <= 1'b1;
      bit_r     <= '0;
    end else if (adv) begin
      arr_v_r <= issue;
      if (issue) begin
        arr_byp_r <= cur_c.leaf;
        arr_eob_r <= (bit_r == 3'd0);
      end
      if (arr_v_r && !issue) begin
        at_root_r <= arr_node.leaf;
      end
      if (load_go) begin
        at_root_r <= 1'b1;
      end
      if (dec_go) begin
        busy_r <= 1'b1;
        bit_r  <= 3'd7;
      end else if (issue) begin
        busy_r <= (bit_r != 3'd0);
        bit_r  <= bit_r - 1'b1;
      end
    end
  end

  // Walk payload registers
  always_ff @(posedge clk) begin
    if (adv && issue && cur_c.leaf) begin
      byp_r <= cur_c;
    end
    if (adv && arr_v_r && !issue) begin
      cur_r <= arr_node;
    end
    if (dec_go) begin
      byte_r <= cmd.data_byte;
    end
    if (wr_en && cmd.node_index == 9'd0) begin
      root_r <= node_wr;
    end
  end

  // Node table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= node_wr;
    end
    if (rd_en) begin
      mem_q_r <= node_mem[rd_addr];
    end
  end

  `HTW_ASSERT_NEVER(a_walk_rd_wr_clash, clk, rst_n, rd_en && wr_en, "node read during node write")
  `HTW_ASSERT_NEXT(a_walk_load_root, clk, rst_n, load_go, at_root_r && !arr_v_r && !busy_r, "load did not return walk to root")

endmodule

`default_nettype wire

>>> design/htw_count.sv
// Count stage: check and decrement symbol counts, format results, hold stop
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_tree_walk_decoder_assert.svh"

module htw_count #(
  parameter int SYMBOL_COUNT = htw_pkg::SYMBOL_COUNT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           tok_valid,
  output logic                tok_ready,
  input  wire htw_pkg::tok_t  tok,
  htw_out_if.source           out_ch
);

  localparam int SymAw = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam logic [8:0] SymLimit = 9'(SYMBOL_COUNT);

  logic [31:0] cnt_mem [0:SYMBOL_COUNT-1];
  logic [SYMBOL_COUNT-1:0] cnt_vld_r;

  htw_pkg::tok_t a_tok_r;
  logic          a_v_r, cv_r, fw_v_r, halted_r;
  logic [31:0]   cq_r, fw_val_r;
  logic [SymAw-1:0] fw_idx_r;
  logic          out_v_r, out_last_r, out_stop_r;
  logic [7:0]    out_sym_r;

  logic [SymAw-1:0] a_idx, pop_idx;
  logic          a_in_rng, emit, exhausted, need_look, look_eob, out_free, fire;
  logic          wr_en;
  logic [31:0]   cnt_cur, wr_val;

  // Current count, with the last write forwarded over the registered read
  assign a_idx    = SymAw'(a_tok_r.sym);
  assign pop_idx  = SymAw'(tok.sym);
  assign a_in_rng = ({1'b0, a_tok_r.sym} < SymLimit);
  assign cnt_cur  = (fw_v_r && fw_idx_r == a_idx) ? fw_val_r : (cv_r ? cq_r : '0);

  // Last result of a byte: stop, leaf on the final bit, or end marker next
  assign emit      = a_v_r && (a_tok_r.kind == htw_pkg::TOK_SYM) && !halted_r;
  assign exhausted = !a_in_rng || (cnt_cur == '0);
  assign need_look = !exhausted && !a_tok_r.eob;
  assign look_eob  = tok_valid && (tok.kind == htw_pkg::TOK_EOB);
  assign out_free  = !out_v_r || out_ch.ready;
  assign fire      = a_v_r && (!emit || (out_free && (!need_look || tok_valid)));
  assign tok_ready = !a_v_r || fire;

  // Count updates: decrement on a hit, overwrite on a count load
  always_comb begin
    wr_en  = 1'b0;
    wr_val = cnt_cur - 32'd1;
    if (fire && emit && !exhausted) begin
      wr_en = 1'b1;
    end
    if (fire && a_tok_r.kind == htw_pkg::TOK_LOAD && a_tok_r.is_cnt && a_in_rng) begin
      wr_en  = 1'b1;
      wr_val = a_tok_r.count;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r     <= 1'b0;
      halted_r  <= 1'b0;
      fw_v_r    <= 1'b0;
      cnt_vld_r <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (tok_ready) begin
        a_v_r <= tok_valid;
      end
      if (fire && emit && exhausted) begin
        halted_r <= 1'b1;
      end
      if (fire && a_tok_r.kind == htw_pkg::TOK_LOAD) begin
        halted_r <= 1'b0;
      end
      if (wr_en) begin
        fw_v_r           <= 1'b1;
        cnt_vld_r[a_idx] <= 1'b1;
      end
      if (fire && emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Stage and result payload
  always_ff @(posedge clk) begin
    if (tok_ready && tok_valid) begin
      a_tok_r <= tok;
      cv_r    <= cnt_vld_r[pop_idx];
    end
    if (wr_en) begin
      fw_idx_r <= a_idx;
      fw_val_r <= wr_val;
    end
    if (fire && emit) begin
      out_sym_r  <= exhausted ? 8'd0 : a_tok_r.sym;
      out_stop_r <= exhausted;
      out_last_r <= exhausted || a_tok_r.eob || look_eob;
    end
  end

  // Count memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[a_idx] <= wr_val;
    end
    if (tok_ready && tok_valid) begin
      cq_r <= cnt_mem[pop_idx];
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.decoded_symbol = out_sym_r;
  assign out_ch.last_in_run    = out_last_r;
  assign out_ch.stopped        = out_stop_r;

  `HTW_ASSERT_NEXT(a_cnt_marker_halts, clk, rst_n, fire && emit && exhausted, halted_r && out_v_r && out_stop_r && out_last_r, "stop marker did not halt")
  `HTW_ASSERT_IMPLIES(a_cnt_stop_form, clk, rst_n, out_v_r && out_stop_r, out_sym_r == 8'd0 && out_last_r, "malformed stop marker")

endmodule

`default_nettype wire

>>> design/huffman_tree_walk_decoder.sv
// Top level of the bit-serial tree-walk decoder
// Decode items: one node-table read per bit (walker loop); the next byte is taken at the last bit.
// Load items: taken once the walk of earlier bytes has finished.
// Reset: synchronous, active low; clears queues, walk to root, stop flag, count
// valid bits. The node table is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_walk_decoder #(
  parameter int NODE_DEPTH   = htw_pkg::NODE_DEPTH_DEF,
  parameter int SYMBOL_COUNT = htw_pkg::SYMBOL_COUNT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  htw_in_if.sink     in_ch,
  htw_out_if.source  out_ch
);

  htw_pkg::cmd_t cmd_push, cmd_pop;
  htw_pkg::tok_t tok_push, tok_pop;
  logic cmd_push_valid, cmd_push_ready, cmd_pop_valid, cmd_pop_ready;
  logic tok_push_valid, tok_push_ready, tok_pop_valid, tok_pop_ready;

  htw_front #(.NODE_DEPTH(NODE_DEPTH)) u_front (
    .in_ch     (in_ch),
    .cmd_valid (cmd_push_valid),
    .cmd_ready (cmd_push_ready),
    .cmd       (cmd_push)
  );

  htw_fifo #(
    .WIDTH($bits(htw_pkg::cmd_t)),
    .DEPTH(htw_pkg::CMD_QDEPTH)
  ) u_cmd_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cmd_push_valid),
    .push_ready (cmd_push_ready),
    .push_data  (cmd_push),
    .pop_valid  (cmd_pop_valid),
    .pop_ready  (cmd_pop_ready),
    .pop_data   (cmd_pop)
  );

  htw_walk #(.NODE_DEPTH(NODE_DEPTH)) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_pop_valid),
    .cmd_ready (cmd_pop_ready),
    .cmd       (cmd_pop),
    .tok_valid (tok_push_valid),
    .tok_ready (tok_push_ready),
    .tok       (tok_push)
  );

  htw_fifo #(
    .WIDTH($bits(htw_pkg::tok_t)),
    .DEPTH(htw_pkg::TOK_QDEPTH)
  ) u_tok_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (tok_push_valid),
    .push_ready (tok_push_ready),
    .push_data  (tok_push),
    .pop_valid  (tok_pop_valid),
    .pop_ready  (tok_pop_ready),
    .pop_data   (tok_pop)
  );

  htw_count #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_pop_valid),
    .tok_ready (tok_pop_ready),
    .tok       (tok_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
